FILE: src/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// No dependencies; used by bsa_chunk_scan and bitmap_slot_allocator.
package bsa_pkg;

  // default depth of the used-slot bitmap
  localparam int unsigned DEF_MAX_ENTRIES = 64;
  // address space width; slot addresses wrap at this many bits
  localparam int unsigned ADDR_BITS = 32;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CTR_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SPAN_W   = SIZE_W + COUNT_W;
  localparam int unsigned CHUNK_W  = 8;
  localparam int unsigned CIDX_W   = 3;

  // result data: slot_address, alloc, miss, free counters, in_use, pad to bytes
  localparam int unsigned OUT_RAW_W  = ADDR_W + 3 * CTR_W + COUNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ELEM_SIZE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ELEM_COUNT = 2'd2;

  typedef struct packed {
    logic              any_free;
    logic [CIDX_W-1:0] first_free;
    logic [CIDX_W:0]   used_cnt;
  } scan_res_t;

endpackage

FILE: src/bitmap_slot_allocator.sv
// Slot allocator over a used-slot bitmap, one request at a time. The slot count n is
// elem_count capped at MAX_ENTRIES; a free is first checked against both ends of the
// pool. The bitmap is scanned eight slots a cycle for the lowest free slot and the
// in-use count, and a free runs a seven-step restoring division on one shared
// subtractor. One 16x7 multiplier serves both the pool span and the slot address.
// s_axis_tready is high only between requests; a finished result waits in the output
// register, and the next item stalls only if that register is still full when it ends.
module bitmap_slot_allocator #(
  parameter int unsigned MAX_ENTRIES = bsa_pkg::DEF_MAX_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bsa_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  // requests
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // address
  input  logic [0:0]                        s_axis_tuser,  // op
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // slot_address, alloc_count, miss_count, free_count, in_use, zero pad
  output logic [bsa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [bsa_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);
  import bsa_pkg::*;

  localparam int unsigned IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned NCHUNK   = (MAX_ENTRIES + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned CH_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned CMP_W    = (CH_W > 4) ? CH_W : 4;
  localparam int unsigned POS_W    = CMP_W + CIDX_W;
  localparam int unsigned MAX_CLIP = (MAX_ENTRIES > 127) ? 127 : MAX_ENTRIES;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RANGE_LO = 4'd1;
  localparam logic [3:0] ST_RANGE_HI = 4'd2;
  localparam logic [3:0] ST_DIV      = 4'd3;
  localparam logic [3:0] ST_CLEAR    = 4'd4;
  localparam logic [3:0] ST_SCAN     = 4'd5;
  localparam logic [3:0] ST_DECIDE   = 4'd6;
  localparam logic [3:0] ST_SET      = 4'd7;
  localparam logic [3:0] ST_ADDR     = 4'd8;
  localparam logic [3:0] ST_FINISH   = 4'd9;

  // control state
  logic [3:0]             state_q, state_d;
  logic [ADDR_W-1:0]      pool_base_q;
  logic [SIZE_W-1:0]      elem_size_q;
  logic [COUNT_W-1:0]     elem_count_q;
  logic [MAX_ENTRIES-1:0] used_map_q, used_map_d;
  logic [CTR_W-1:0]       allocs_q, allocs_d, misses_q, misses_d, frees_q, frees_d;
  logic                   out_valid_q, out_valid_d;

  // working registers
  logic                   op_q, op_d;
  logic [ADDR_W-1:0]      addr_in_q, addr_in_d;
  logic [COUNT_W-1:0]     n_q, n_d;
  logic [SPAN_W-1:0]      product_q, product_d;
  logic [ADDR_W-1:0]      off_q, off_d;
  logic [SPAN_W-1:0]      rem_q, rem_d;
  logic [2:0]             k_q, k_d;
  logic [COUNT_W-1:0]     slot_q, slot_d;
  logic                   found_q, found_d;
  logic [CH_W-1:0]        chunk_q, chunk_d;
  logic [COUNT_W-1:0]     cnt_q, cnt_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [ADDR_W-1:0]      addr_out_q, addr_out_d;
  logic [OUT_DATA_W-1:0]  out_data_q, out_data_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;

  logic                   in_acc;
  logic [COUNT_W-1:0]     n_eff;
  logic [COUNT_W-1:0]     mul_b;
  logic [SPAN_W-1:0]      mul_p;
  logic [ADDR_W-1:0]      alu_a, alu_b;
  logic [ADDR_W:0]        alu_diff;
  logic                   alu_borrow;
  logic [SPAN_W-1:0]      divisor;
  logic [NCHUNK-1:0][CHUNK_W-1:0] map_pad;
  logic [CHUNK_W-1:0]     live;
  logic [3:0]             last_chunk;
  logic                   is_last;
  logic [IDX_W-1:0]       slot_idx;
  logic [3:0]             scan_exit;
  logic [3:0]             scan_entry;
  scan_res_t              scan_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  assign n_eff = (elem_count_q > COUNT_W'(MAX_CLIP)) ? COUNT_W'(MAX_CLIP) : elem_count_q;

  // shared multiplier: pool span on entry, slot offset after allocation
  assign mul_b = (state_q == ST_IDLE) ? n_eff : slot_q;
  assign mul_p = SPAN_W'({{COUNT_W{1'b0}}, elem_size_q} * {{SIZE_W{1'b0}}, mul_b});

  // shared subtractor: range checks and division steps
  assign divisor = SPAN_W'({{COUNT_W{1'b0}}, elem_size_q} << k_q);
  always_comb begin
    case (state_q)
      ST_RANGE_LO: begin
        alu_a = addr_in_q;
        alu_b = pool_base_q;
      end
      ST_RANGE_HI: begin
        alu_a = off_q;
        alu_b = ADDR_W'(product_q);
      end
      default: begin
        alu_a = ADDR_W'(rem_q);
        alu_b = ADDR_W'(divisor);
      end
    endcase
  end
  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[ADDR_W];

  // bitmap viewed in eight-slot chunks
  always_comb begin
    map_pad = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      map_pad[i >> 3][i & 7] = used_map_q[i];
    end
  end

  always_comb begin
    for (int j = 0; j < CHUNK_W; j++) begin
      live[j] = ({POS_W'(chunk_q), CIDX_W'(0)} | (POS_W + CIDX_W)'(j))
                < (POS_W + CIDX_W)'(n_q);
    end
  end

  bsa_chunk_scan u_scan (
    .used_i (map_pad[chunk_q]),
    .live_i (live),
    .res_o  (scan_res)
  );

  assign last_chunk = 4'((n_q - COUNT_W'(1)) >> 3);
  assign is_last    = (CMP_W'(chunk_q) == CMP_W'(last_chunk));
  assign slot_idx   = IDX_W'(slot_q);
  assign scan_exit  = (op_q == OP_ALLOC) ? ST_DECIDE : ST_FINISH;
  assign scan_entry = (n_q == '0) ? scan_exit : ST_SCAN;

  always_comb begin
    state_d     = state_q;
    used_map_d  = used_map_q;
    allocs_d    = allocs_q;
    misses_d    = misses_q;
    frees_d     = frees_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    addr_in_d   = addr_in_q;
    n_d         = n_q;
    product_d   = product_q;
    off_d       = off_q;
    rem_d       = rem_q;
    k_d         = k_q;
    slot_d      = slot_q;
    found_d     = found_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    addr_out_d  = addr_out_q;
    out_data_d  = out_data_q;
    out_status_d = out_status_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d       = s_axis_tuser[0];
          addr_in_d  = s_axis_tdata;
          n_d        = n_eff;
          product_d  = mul_p;
          status_d   = STATUS_OK;
          slot_d     = '0;
          addr_out_d = '0;
          cnt_d      = '0;
          chunk_d    = '0;
          found_d    = 1'b0;
          if (s_axis_tuser[0] == OP_FREE) begin
            state_d = ST_RANGE_LO;
          end else begin
            state_d = (n_eff == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
      end
      ST_RANGE_LO: begin
        if (alu_borrow) begin
          status_d = STATUS_RANGE;
          state_d  = scan_entry;
        end else begin
          off_d   = alu_diff[ADDR_W-1:0];
          state_d = ST_RANGE_HI;
        end
      end
      ST_RANGE_HI: begin
        if (!alu_borrow) begin
          status_d = STATUS_RANGE;
          state_d  = scan_entry;
        end else begin
          // offset is below the span, so it fits the remainder
          rem_d   = off_q[SPAN_W-1:0];
          k_d     = 3'(COUNT_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!alu_borrow) begin
          rem_d       = alu_diff[SPAN_W-1:0];
          slot_d[k_q] = 1'b1;
        end
        if (k_q == '0) begin
          state_d = ST_CLEAR;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      ST_CLEAR: begin
        used_map_d[slot_idx] = 1'b0;
        frees_d = frees_q + CTR_W'(1);
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + COUNT_W'(scan_res.used_cnt);
        if (op_q == OP_ALLOC && !found_q && scan_res.any_free) begin
          found_d = 1'b1;
          slot_d  = COUNT_W'({POS_W'(chunk_q), scan_res.first_free});
        end
        if (is_last) begin
          state_d = scan_exit;
        end else begin
          chunk_d = chunk_q + CH_W'(1);
        end
      end
      ST_DECIDE: begin
        if (found_q) begin
          state_d = ST_SET;
        end else begin
          status_d = STATUS_NO_SLOT;
          misses_d = misses_q + CTR_W'(1);
          state_d  = ST_FINISH;
        end
      end
      ST_SET: begin
        used_map_d[slot_idx] = 1'b1;
        allocs_d  = allocs_q + CTR_W'(1);
        cnt_d     = cnt_q + COUNT_W'(1);
        product_d = mul_p;
        state_d   = ST_ADDR;
      end
      ST_ADDR: begin
        addr_out_d = (pool_base_q + ADDR_W'(product_q)) & ADDR_MASK;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_data_d   = OUT_DATA_W'({cnt_q, frees_q, misses_q, allocs_q, addr_out_q});
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pool_base_q  <= '0;
      elem_size_q  <= SIZE_W'(1);
      elem_count_q <= COUNT_W'(64);
      used_map_q   <= '0;
      allocs_q     <= '0;
      misses_q     <= '0;
      frees_q      <= '0;
      out_valid_q  <= 1'b0;
      op_q         <= OP_ALLOC;
      n_q          <= '0;
      k_q          <= '0;
      found_q      <= 1'b0;
      chunk_q      <= '0;
    end else begin
      state_q     <= state_d;
      used_map_q  <= used_map_d;
      allocs_q    <= allocs_d;
      misses_q    <= misses_d;
      frees_q     <= frees_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      n_q         <= n_d;
      k_q         <= k_d;
      found_q     <= found_d;
      chunk_q     <= chunk_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_POOL_BASE:  pool_base_q  <= cfg_data_i[ADDR_W-1:0];
          REG_ELEM_SIZE:  elem_size_q  <= cfg_data_i[SIZE_W-1:0];
          REG_ELEM_COUNT: elem_count_q <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_in_q    <= addr_in_d;
    product_q    <= product_d;
    off_q        <= off_d;
    rem_q        <= rem_d;
    slot_q       <= slot_d;
    cnt_q        <= cnt_d;
    status_q     <= status_d;
    addr_out_q   <= addr_out_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

endmodule

FILE: src/bsa_chunk_scan.sv
// One eight-slot slice of the bitmap: lowest free slot and used count.
// Depends on bsa_pkg.
module bsa_chunk_scan (
  input  logic [7:0]          used_i,
  input  logic [7:0]          live_i,  // slot lies below the slot count
  output bsa_pkg::scan_res_t  res_o
);
  import bsa_pkg::*;

  always_comb begin
    res_o = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (live_i[j] && !used_i[j]) begin
        res_o.any_free   = 1'b1;
        res_o.first_free = CIDX_W'(j);
      end
    end
    for (int j = 0; j < CHUNK_W; j++) begin
      res_o.used_cnt = res_o.used_cnt + (CIDX_W + 1)'(live_i[j] & used_i[j]);
    end
  end

endmodule
